/* rtl/core/multidim_box_range_query_defines.svh */
// Assertion macros shared by the checker of the box range query block.
`ifndef MULTIDIM_BOX_RANGE_QUERY_DEFINES_SVH
`define MULTIDIM_BOX_RANGE_QUERY_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define MBRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication into the next cycle, outside reset.
`define MBRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mbrq_pkg.sv */
// Types, codes and helpers for the box range query block.
`default_nettype none
package mbrq_pkg;

    localparam int MAX_DIMS = 4;
    localparam int COORD_W  = 32;
    localparam int ID_W     = 16;
    localparam int ROW_W    = MAX_DIMS * COORD_W;
    localparam logic [COORD_W-1:0] SIGN_FLIP = 32'h8000_0000;
    localparam logic [2:0] DIMS_RESET = 3'd3;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_FETCH  = 2'd2;

    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_INC   = 3'd2;
    localparam logic [2:0] IDX_DEC   = 3'd3;
    localparam logic [2:0] IDX_COUNT = 3'd4;

    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_ZERO = 2'd1;
    localparam logic [1:0] CUR_INC  = 2'd2;

    localparam logic [1:0] OA_IDX    = 2'd0;
    localparam logic [1:0] OA_IDX_M1 = 2'd1;
    localparam logic [1:0] OA_CUR    = 2'd2;

    localparam logic [1:0] RES_ZERO   = 2'd0;
    localparam logic [1:0] RES_FOUND  = 2'd1;
    localparam logic [1:0] RES_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] key_0;
        logic signed [COORD_W-1:0] key_1;
        logic signed [COORD_W-1:0] key_2;
        logic signed [COORD_W-1:0] key_3;
        logic signed [COORD_W-1:0] upper_0;
        logic signed [COORD_W-1:0] upper_1;
        logic signed [COORD_W-1:0] upper_2;
        logic signed [COORD_W-1:0] upper_3;
        logic [ID_W-1:0]           point_id;
    } t_in_req;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] result_id;
        logic            rejected;
    } t_out_res;

    typedef struct packed {
        logic       load_req;
        logic       wr_point;
        logic       box_load;
        logic [2:0] idx_op;
        logic [1:0] cur_op;
        logic       ord_rd;
        logic [1:0] ord_addr;
        logic       row_rd;
        logic       ord_wr_shift;
        logic       ord_wr_place;
        logic       pos_load;
        logic       res_load;
        logic [1:0] res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       idx_lt_count;
        logic       cur_lt_count;
        logic       idx_gt_pos;
        logic       key_le;
        logic       key_lt_low;
        logic       key_gt_high;
        logic       other_in;
    } t_dp_status;

    // Flipping the sign bit makes an unsigned compare follow signed order.
    function automatic logic [COORD_W-1:0] biased(input logic [COORD_W-1:0] v);
        return v ^ SIGN_FLIP;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/mbrq_dpath.sv */
// Datapath: point, id and order memories, cursor, box and result register.
`default_nettype none
module mbrq_dpath
    import mbrq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_req    i_in_req,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    output t_out_res        o_out_res
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [ROW_W-1:0] r_coord_mem [CAPACITY];
    logic [ID_W-1:0]  r_id_mem    [CAPACITY];
    logic [IW-1:0]    r_ord_mem   [CAPACITY];

    t_in_req          r_req;
    logic [ROW_W-1:0] r_row_q;
    logic [ID_W-1:0]  r_id_q;
    logic [IW-1:0]    r_ord_q;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_pos;
    logic [COORD_W-1:0] r_low  [MAX_DIMS];
    logic [COORD_W-1:0] r_high [MAX_DIMS];
    logic [2:0]       r_dims;
    t_out_res         r_res;

    logic [CW-1:0]    idx_m1;
    logic [IW-1:0]    ord_rd_addr;
    logic [COORD_W-1:0] row_key0;
    logic [2:0]       axes;
    logic             other_in;

    assign idx_m1   = r_idx - CW'(1);
    assign row_key0 = r_row_q[COORD_W-1:0];

    always_comb begin
        unique case (i_cmd.ord_addr)
            OA_IDX:    ord_rd_addr = r_idx[IW-1:0];
            OA_IDX_M1: ord_rd_addr = idx_m1[IW-1:0];
            default:   ord_rd_addr = r_cursor[IW-1:0];
        endcase
    end

    always_comb begin
        if (r_dims == 3'd0) begin
            axes = 3'd1;
        end else if (r_dims > 3'(MAX_DIMS)) begin
            axes = 3'(MAX_DIMS);
        end else begin
            axes = r_dims;
        end
    end

    always_comb begin
        logic [COORD_W-1:0] c;
        other_in = 1'b1;
        for (int a = 1; a < MAX_DIMS; a++) begin
            c = r_row_q[a*COORD_W +: COORD_W];
            if (3'(a) < axes && (c < r_low[a] || c > r_high[a])) begin
                other_in = 1'b0;
            end
        end
    end

    always_comb begin
        o_status.op           = r_req.op;
        o_status.full         = (r_count == CAP_C);
        o_status.idx_lt_count = (r_idx < r_count);
        o_status.cur_lt_count = (r_cursor < r_count);
        o_status.idx_gt_pos   = (r_idx > r_pos);
        o_status.key_le       = (row_key0 <= biased(r_req.key_0));
        o_status.key_lt_low   = (row_key0 < r_low[0]);
        o_status.key_gt_high  = (row_key0 > r_high[0]);
        o_status.other_in     = other_in;
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = r_idx + CW'(1);
            IDX_DEC:   n_idx = idx_m1;
            IDX_COUNT: n_idx = r_count;
            default:   n_idx = r_idx;
        endcase
    end

    // Placing an entry at or before the cursor moves the cursor along with it.
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        if (i_cmd.ord_wr_place) begin
            n_count = r_count + CW'(1);
            if (r_pos <= r_cursor && r_cursor < n_count) begin
                n_cursor = r_cursor + CW'(1);
            end
        end else begin
            unique case (i_cmd.cur_op)
                CUR_ZERO: n_cursor = '0;
                CUR_INC:  n_cursor = r_cursor + CW'(1);
                default:  n_cursor = r_cursor;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point) begin
            r_coord_mem[r_count[IW-1:0]] <= {biased(r_req.key_3), biased(r_req.key_2),
                                             biased(r_req.key_1), biased(r_req.key_0)};
            r_id_mem[r_count[IW-1:0]] <= r_req.point_id;
        end
        if (i_cmd.row_rd) begin
            r_row_q <= r_coord_mem[r_ord_q];
            r_id_q  <= r_id_mem[r_ord_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ord_wr_shift) begin
            r_ord_mem[r_idx[IW-1:0]] <= r_ord_q;
        end else if (i_cmd.ord_wr_place) begin
            r_ord_mem[r_pos[IW-1:0]] <= r_count[IW-1:0];
        end
        if (i_cmd.ord_rd) begin
            r_ord_q <= r_ord_mem[ord_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_req;
        end
        if (i_cmd.pos_load) begin
            r_pos <= r_idx;
        end
        r_idx <= n_idx;
        if (i_cmd.res_load) begin
            r_res.found     <= (i_cmd.res_kind == RES_FOUND);
            r_res.result_id <= (i_cmd.res_kind == RES_FOUND) ? r_id_q : '0;
            r_res.rejected  <= (i_cmd.res_kind == RES_REJECT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_dims   <= DIMS_RESET;
            for (int a = 0; a < MAX_DIMS; a++) begin
                r_low[a]  <= '0;
                r_high[a] <= '0;
            end
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (i_cfg_we) begin
                r_dims <= i_cfg_wdata;
            end
            if (i_cmd.box_load) begin
                r_low[0]  <= biased(r_req.key_0);
                r_low[1]  <= biased(r_req.key_1);
                r_low[2]  <= biased(r_req.key_2);
                r_low[3]  <= biased(r_req.key_3);
                r_high[0] <= biased(r_req.upper_0);
                r_high[1] <= biased(r_req.upper_1);
                r_high[2] <= biased(r_req.upper_2);
                r_high[3] <= biased(r_req.upper_3);
            end
        end
    end

    assign o_out_res = r_res;

endmodule
`default_nettype wire

/* rtl/core/mbrq_ctrl.sv */
// Controller: sequences insert, start-search and fetch over the datapath.
`default_nettype none
module mbrq_ctrl
    import mbrq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_INS_ORD  = 4'd2;
    localparam logic [3:0] S_INS_ROW  = 4'd3;
    localparam logic [3:0] S_INS_EVAL = 4'd4;
    localparam logic [3:0] S_SH_CHK   = 4'd5;
    localparam logic [3:0] S_SH_WR    = 4'd6;
    localparam logic [3:0] S_PLACE    = 4'd7;
    localparam logic [3:0] S_ST_ORD   = 4'd8;
    localparam logic [3:0] S_ST_ROW   = 4'd9;
    localparam logic [3:0] S_ST_EVAL  = 4'd10;
    localparam logic [3:0] S_FE_ORD   = 4'd11;
    localparam logic [3:0] S_FE_ROW   = 4'd12;
    localparam logic [3:0] S_FE_EVAL  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] r_state, n_state;
    logic [1:0] r_kind, n_kind;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_kind  = RES_ZERO;
                n_state = S_DONE;
                priority case (i_status.op)
                    OP_INSERT: begin
                        if (i_status.full) begin
                            n_kind = RES_REJECT;
                        end else begin
                            o_cmd.wr_point = 1'b1;
                            o_cmd.idx_op   = IDX_ZERO;
                            n_state = S_INS_ORD;
                        end
                    end
                    OP_START: begin
                        o_cmd.box_load = 1'b1;
                        o_cmd.cur_op   = CUR_ZERO;
                        n_state = S_ST_ORD;
                    end
                    OP_FETCH: n_state = S_FE_ORD;
                    default: ;
                endcase
            end
            S_INS_ORD: begin
                if (i_status.idx_lt_count) begin
                    o_cmd.ord_rd   = 1'b1;
                    o_cmd.ord_addr = OA_IDX;
                    n_state = S_INS_ROW;
                end else begin
                    o_cmd.pos_load = 1'b1;
                    o_cmd.idx_op   = IDX_COUNT;
                    n_state = S_SH_CHK;
                end
            end
            S_INS_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state = S_INS_EVAL;
            end
            S_INS_EVAL: begin
                if (i_status.key_le) begin
                    o_cmd.idx_op = IDX_INC;
                    n_state = S_INS_ORD;
                end else begin
                    o_cmd.pos_load = 1'b1;
                    o_cmd.idx_op   = IDX_COUNT;
                    n_state = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                if (i_status.idx_gt_pos) begin
                    o_cmd.ord_rd   = 1'b1;
                    o_cmd.ord_addr = OA_IDX_M1;
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SH_WR: begin
                o_cmd.ord_wr_shift = 1'b1;
                o_cmd.idx_op       = IDX_DEC;
                n_state = S_SH_CHK;
            end
            S_PLACE: begin
                o_cmd.ord_wr_place = 1'b1;
                n_kind  = RES_ZERO;
                n_state = S_DONE;
            end
            S_ST_ORD: begin
                if (i_status.cur_lt_count) begin
                    o_cmd.ord_rd   = 1'b1;
                    o_cmd.ord_addr = OA_CUR;
                    n_state = S_ST_ROW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ST_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state = S_ST_EVAL;
            end
            S_ST_EVAL: begin
                if (i_status.key_lt_low) begin
                    o_cmd.cur_op = CUR_INC;
                    n_state = S_ST_ORD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FE_ORD: begin
                if (i_status.cur_lt_count) begin
                    o_cmd.ord_rd   = 1'b1;
                    o_cmd.ord_addr = OA_CUR;
                    n_state = S_FE_ROW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FE_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state = S_FE_EVAL;
            end
            S_FE_EVAL: begin
                // The first-axis bound ends the walk without moving the cursor.
                if (i_status.key_gt_high) begin
                    n_state = S_DONE;
                end else if (i_status.other_in) begin
                    o_cmd.cur_op = CUR_INC;
                    n_kind  = RES_FOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.cur_op = CUR_INC;
                    n_state = S_FE_ORD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = r_kind;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= RES_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

/* rtl/core/multidim_box_range_query.sv */
// Top level of the box range query block: controller plus datapath.
//
// One request channel (i_in_valid, o_in_stall, i_in_req) and one result
// channel (o_out_valid, i_out_stall, o_out_res). Every request gives one result.
// Requests are taken one at a time; o_in_stall is high from acceptance until
// the result has been loaded into the output register. The next request is
// accepted once o_in_stall has fallen again, so no two requests are in flight.
// Steps per request, with entries kept in order of their first-axis key:
//   insert: walk while the stored key is not above the new key, shift the later
//   entries up one slot and place the new point; a full table rejects the insert.
//   start search: load the box, clear the cursor, skip keys below the low bound.
//   fetch: walk from the cursor; a match on every axis stops it past that entry,
//   and the first-axis upper bound or the table end stops it. Unused ops match none.
// Each entry walked costs an order-memory read, a point-memory read and a compare;
// each entry moved on insert costs a read and a write on the order memory.
// A stalled result holds in the output register; the next request is still
// accepted and then waits for the register to free before finishing.
// Synchronous reset empties the table, clears cursor and search box, sets the
// axis count to three and drops any pending result. No clearing pass is needed.
`default_nettype none
module multidim_box_range_query
    import mbrq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_req    i_in_req,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_res        o_out_res,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata
);
    t_dp_cmd    cmd;
    t_dp_status status;

    mbrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mbrq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_res   (o_out_res)
    );

endmodule
`default_nettype wire

/* rtl/core/mbrq_chk.sv */
// Port checker for the box range query block, bound to the top level.
`default_nettype none
`include "multidim_box_range_query_defines.svh"
module mbrq_chk
    import mbrq_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_res o_out_res
);
    `MBRQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_res), "stalled result changed")
    `MBRQ_ASSERT(a_id_zero, !(o_out_valid && !o_out_res.found) || (o_out_res.result_id == '0), "id set without a match")
    `MBRQ_ASSERT(a_excl, !(o_out_valid && o_out_res.found && o_out_res.rejected), "found and rejected together")
    `MBRQ_ASSERT_NEXT(a_one_req, i_in_valid && !o_in_stall, o_in_stall, "second request taken while busy")
endmodule

bind multidim_box_range_query mbrq_chk u_mbrq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);
`default_nettype wire
